// ===== hdl/sddc_pkg.sv =====
// shared constants, types and the month lookup for the serial date day count
package sddc_pkg;

    localparam int unsigned SERIAL_MAX  = 73050;
    localparam int unsigned BLOCK_DAYS  = 1461;
    localparam int unsigned YEAR_DAYS   = 365;
    localparam int unsigned DAYS_MONTH  = 30;
    localparam int unsigned DAYS_YEAR   = 360;
    localparam int unsigned LONG_DAY    = 31;

    // floor(x / 1461) == (x * RECIP_MUL) >> RECIP_SHIFT for every x below 2^17 / 1.79
    localparam int unsigned RECIP_MUL   = 45934;
    localparam int unsigned RECIP_SHIFT = 26;

    localparam int SERIAL_W = 17;
    localparam int COUNT_W  = 18;

    typedef enum logic [1:0] {
        MODE_US  = 2'd0,
        MODE_EU  = 2'd1,
        MODE_ACT = 2'd2,
        MODE_ALT = 2'd3
    } mode_t;

    // cumulative days before each month, non-leap year, index 1 = january
    localparam logic [8:0] MONTH_START [14] = '{
        9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    // stage 1: offset from day one and its 1461-day block
    typedef struct packed {
        logic [SERIAL_W-1:0] x;
        logic [5:0]          q;
    } blk_t;

    // stage 2: offset inside block and year
    typedef struct packed {
        logic [10:0] r;
        logic [1:0]  yr;
    } yoff_t;

    // stage 3: day of year and month hints
    typedef struct packed {
        logic [8:0] k;
        logic       lt31;
        logic       lt60;
        logic       yr_nz;
        logic [7:0] y;
    } doy_t;

    // stage 4: decoded date
    typedef struct packed {
        logic [4:0] d;
        logic [3:0] m;
        logic [7:0] y;
    } date_t;

    // fields that ride along every stage
    typedef struct packed {
        logic               bad;
        mode_t              mode;
        logic [COUNT_W-1:0] act;
    } ctl_t;

    function automatic logic [3:0] month_of(input logic [8:0] k, input logic lt31,
                                            input logic lt60);
        logic [3:0] m;
        m = 4'd1;
        if (lt31) begin
            m = 4'd1;
        end
        else if (lt60) begin
            m = 4'd2;
        end
        else begin
            // table is monotone, so the last passed boundary wins
            for (int j = 2; j <= 12; j++) begin
                if (k > MONTH_START[j]) begin
                    m = 4'(j);
                end
            end
        end
        return m;
    endfunction

endpackage

// ===== hdl/serial_date_day_count.sv =====
// five-stage pipeline: date decode of both serials and 30/360 or actual day count
// throughput: one word per cycle unless a held result word stalls; the serial decode runs as reciprocal multiply,
//   block remainder with year split, day of year, month search and count stages
// a held result word stalls every stage together, nothing is dropped or repeated
// reset clears all stage valid bits; data registers are not reset
module serial_date_day_count (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            valid,
    output logic                            ready,
    input  logic [sddc_pkg::SERIAL_W-1:0]   start_serial,
    input  logic [sddc_pkg::SERIAL_W-1:0]   end_serial,
    input  logic [1:0]                      mode,
    output logic                            count_valid,
    input  logic                            count_ready,
    output logic signed [sddc_pkg::COUNT_W-1:0] day_count,
    output logic                            invalid
);
    import sddc_pkg::*;

    logic adv;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    blk_t  s1_reg  [2];
    blk_t  s1_next [2];
    ctl_t  c1_reg, c1_next;
    yoff_t s2_reg  [2];
    yoff_t s2_next [2];
    logic [5:0] q2_reg [2];
    ctl_t  c2_reg;
    doy_t  s3_reg  [2];
    doy_t  s3_next [2];
    ctl_t  c3_reg;
    date_t s4_reg  [2];
    date_t s4_next [2];
    ctl_t  c4_reg;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               bad_reg;

    logic [SERIAL_W-1:0] ser [2];

    assign ser[0] = start_serial;
    assign ser[1] = end_serial;

    assign adv   = !v5_reg || count_ready;
    assign ready = adv;

    // stage 1: validity, offset and block number by reciprocal multiply
    always_comb begin
        logic [32:0] p;
        logic        ok0, ok1;
        for (int i = 0; i < 2; i++) begin
            s1_next[i].x = ser[i] - SERIAL_W'(1);
            p            = 33'(s1_next[i].x) * 33'(RECIP_MUL);
            s1_next[i].q = p[RECIP_SHIFT+5:RECIP_SHIFT];
        end
        ok0 = (start_serial >= SERIAL_W'(1)) && (start_serial <= SERIAL_W'(SERIAL_MAX));
        ok1 = (end_serial >= SERIAL_W'(1)) && (end_serial <= SERIAL_W'(SERIAL_MAX));
        c1_next.bad  = !(ok0 && ok1);
        c1_next.mode = mode_t'(mode);
        c1_next.act  = COUNT_W'(end_serial) - COUNT_W'(start_serial);
    end

    // stage 2: offset inside the block and year inside the block
    always_comb begin
        logic [SERIAL_W-1:0] rt;
        logic [10:0]         r;
        for (int i = 0; i < 2; i++) begin
            rt = s1_reg[i].x - SERIAL_W'(s1_reg[i].q) * SERIAL_W'(BLOCK_DAYS);
            r  = rt[10:0];
            s2_next[i].r = r;
            // first year of a block is the leap one with 366 days
            if (r >= 11'(3 * YEAR_DAYS + 1)) begin
                s2_next[i].yr = 2'd3;
            end
            else if (r >= 11'(2 * YEAR_DAYS + 1)) begin
                s2_next[i].yr = 2'd2;
            end
            else if (r >= 11'(YEAR_DAYS + 1)) begin
                s2_next[i].yr = 2'd1;
            end
            else begin
                s2_next[i].yr = 2'd0;
            end
        end
    end

    // stage 3: day of year, counted without the leap day
    always_comb begin
        logic [10:0] kt;
        for (int i = 0; i < 2; i++) begin
            kt = s2_reg[i].r - 11'(s2_reg[i].yr) * 11'(YEAR_DAYS);
            s3_next[i].k     = kt[8:0];
            s3_next[i].lt31  = s2_reg[i].r < 11'd31;
            s3_next[i].lt60  = s2_reg[i].r < 11'd60;
            s3_next[i].yr_nz = s2_reg[i].yr != 2'd0;
            s3_next[i].y     = {q2_reg[i], s2_reg[i].yr};
        end
    end

    // stage 4: month search and day of month
    always_comb begin
        logic [3:0] m;
        logic       c;
        logic [9:0] dt;
        for (int i = 0; i < 2; i++) begin
            m  = month_of(s3_reg[i].k, s3_reg[i].lt31, s3_reg[i].lt60);
            c  = s3_reg[i].yr_nz || (m >= 4'd3);
            dt = 10'(s3_reg[i].k) + 10'd1 - 10'(MONTH_START[m]) - 10'(c);
            s4_next[i].d = dt[4:0];
            s4_next[i].m = m;
            s4_next[i].y = s3_reg[i].y;
        end
    end

    // stage 5: day caps and count, modulo 2^18 gives the two's complement word
    always_comb begin
        logic [4:0] d1, d2;
        d1 = s4_reg[0].d;
        d2 = s4_reg[1].d;
        if (d1 == 5'(LONG_DAY)) begin
            d1 = 5'(DAYS_MONTH);
        end
        if (d2 == 5'(LONG_DAY) && (c4_reg.mode == MODE_EU || d1 == 5'(DAYS_MONTH))) begin
            d2 = 5'(DAYS_MONTH);
        end
        cnt_next = COUNT_W'(d2) - COUNT_W'(d1)
                 + COUNT_W'(s4_reg[1].m) * COUNT_W'(DAYS_MONTH)
                 - COUNT_W'(s4_reg[0].m) * COUNT_W'(DAYS_MONTH)
                 + COUNT_W'(s4_reg[1].y) * COUNT_W'(DAYS_YEAR)
                 - COUNT_W'(s4_reg[0].y) * COUNT_W'(DAYS_YEAR);
        case (c4_reg.mode) inside
            MODE_US, MODE_EU: cnt_next = cnt_next;
            default:          cnt_next = c4_reg.act;
        endcase
        if (c4_reg.bad) begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv) begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            s1_reg  <= s1_next;
            c1_reg  <= c1_next;
            s2_reg  <= s2_next;
            q2_reg[0] <= s1_reg[0].q;
            q2_reg[1] <= s1_reg[1].q;
            c2_reg  <= c1_reg;
            s3_reg  <= s3_next;
            c3_reg  <= c2_reg;
            s4_reg  <= s4_next;
            c4_reg  <= c3_reg;
            cnt_reg <= cnt_next;
            bad_reg <= c4_reg.bad;
        end
    end

    assign count_valid = v5_reg;
    assign day_count   = $signed(cnt_reg);
    assign invalid     = bad_reg;

    // a flagged word always carries a zero count
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        count_valid && invalid |-> day_count == '0)
        else $error("invalid word with nonzero count");

    // any count stays within the span of the serial range
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_valid |-> (day_count >= -18'sd73049) && (day_count <= 18'sd73049))
        else $error("day count out of range");

    // a word in the last decode stage reaches the output on the next advance
    a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
        adv && v4_reg |=> count_valid)
        else $error("word lost between stage 4 and output");

endmodule

// ===== dv/tb_serial_date_day_count.sv =====
// testbench for the serial date day count pipeline: scoreboard class and stimulus tasks
module tb_serial_date_day_count;

    timeunit 1ns;
    timeprecision 1ps;

    import sddc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 12;
    localparam int RANDOM_PER_PHASE = 275;

    logic                       clk;
    logic                       rst_n;
    logic                       valid;
    logic                       ready;
    logic [SERIAL_W-1:0]        start_serial;
    logic [SERIAL_W-1:0]        end_serial;
    logic [1:0]                 mode;
    logic                       count_valid;
    logic                       count_ready;
    logic signed [COUNT_W-1:0]  day_count;
    logic                       invalid;

    int idle_pct;
    int stall_pct;
    int quiet;

    class day_count_board;

        typedef struct {
            logic [SERIAL_W-1:0]       s1;
            logic [SERIAL_W-1:0]       s2;
            logic [1:0]                basis;
            logic signed [COUNT_W-1:0] count;
            logic                      bad;
        } owed_t;

        owed_t       owed[$];
        int unsigned errors;
        int unsigned reported;
        int unsigned words_in;
        int unsigned words_out;
        int unsigned flagged;
        int unsigned per_basis[4];

        function new();
            errors = 0;
            reported = 0;
            words_in = 0;
            words_out = 0;
            flagged = 0;
            foreach (per_basis[i])
            begin
                per_basis[i] = 0;
            end
        endfunction

        // days in the non-leap year before the first of the month
        static function int days_before_month(int mon);
            case (mon)
                2:       return 31;
                3:       return 59;
                4:       return 90;
                5:       return 120;
                6:       return 151;
                7:       return 181;
                8:       return 212;
                9:       return 243;
                10:      return 273;
                11:      return 304;
                12:      return 334;
                13:      return 365;
                default: return 0;
            endcase
        endfunction

        static function int month_first_serial(int mon, int yo);
            int s;
            s = (yo / 4) * int'(BLOCK_DAYS) + (yo % 4) * int'(YEAR_DAYS) +
                days_before_month(mon) + 1;
            // leap day sits in the first year of each block
            if (!((yo % 4) == 0 && mon < 3))
            begin
                s = s + 1;
            end
            return s;
        endfunction

        static function void serial_to_date(int n, output int d, output int mon,
                                            output int yo);
            int r;
            int k;
            r = (n - 1) % int'(BLOCK_DAYS);
            yo = ((n - 1) / int'(BLOCK_DAYS)) * 4;
            if (r >= 1)
            begin
                yo = yo + (r - 1) / int'(YEAR_DAYS);
            end
            if (r < 31)
            begin
                mon = 1;
            end
            else if (r < 60)
            begin
                mon = 2;
            end
            else
            begin
                k = (r - 1) % int'(YEAR_DAYS) + 1;
                mon = 1;
                while (mon < 12 && k > days_before_month(mon + 1))
                begin
                    mon = mon + 1;
                end
            end
            d = n - month_first_serial(mon, yo) + 1;
        endfunction

        static function owed_t predict_day_count(logic [SERIAL_W-1:0] s1,
                                                 logic [SERIAL_W-1:0] s2,
                                                 logic [1:0] mode_bits);
            owed_t  w;
            mode_t  basis;
            int     d1, m1, y1, d2, m2, y2;
            int     c;
            basis = mode_t'(mode_bits);
            w.s1 = s1;
            w.s2 = s2;
            w.basis = mode_bits;
            w.bad = 1'b0;
            c = 0;
            if (s1 < 1 || s1 > SERIAL_MAX || s2 < 1 || s2 > SERIAL_MAX)
            begin
                w.bad = 1'b1;
            end
            else if (basis == MODE_US || basis == MODE_EU)
            begin
                serial_to_date(int'(s1), d1, m1, y1);
                serial_to_date(int'(s2), d2, m2, y2);
                if (d1 == int'(LONG_DAY))
                begin
                    d1 = int'(DAYS_MONTH);
                end
                if (d2 == int'(LONG_DAY) && (basis == MODE_EU || d1 == int'(DAYS_MONTH)))
                begin
                    d2 = int'(DAYS_MONTH);
                end
                c = (d2 - d1) + int'(DAYS_MONTH) * (m2 - m1) + int'(DAYS_YEAR) * (y2 - y1);
            end
            else
            begin
                // actual days, the spare code included
                c = int'(s2) - int'(s1);
            end
            w.count = c[COUNT_W-1:0];
            return w;
        endfunction

        function void note(logic [SERIAL_W-1:0] s1, logic [SERIAL_W-1:0] s2,
                           logic [1:0] mode_bits);
            owed_t w;
            w = predict_day_count(s1, s2, mode_bits);
            owed.push_back(w);
            words_in++;
            per_basis[mode_bits]++;
            if (w.bad)
            begin
                flagged++;
            end
        endfunction

        function void check(logic signed [COUNT_W-1:0] count, logic bad);
            owed_t w;
            words_out++;
            if (owed.size() == 0)
            begin
                errors++;
                if (reported < 10)
                begin
                    $display("unexpected result word: day_count=%0d invalid=%0b", count, bad);
                    reported++;
                end
                return;
            end
            w = owed.pop_front();
            if (count !== w.count || bad !== w.bad)
            begin
                errors++;
                if (reported < 10)
                begin
                    $display("mismatch start=%0d end=%0d mode=%0d: ", w.s1, w.s2, w.basis,
                             "exp count=%0d invalid=%0b, ", w.count, w.bad,
                             "got count=%0d invalid=%0b", count, bad);
                    reported++;
                end
            end
        endfunction

    endclass

    day_count_board board;

    serial_date_day_count dut (.*);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        count_ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && valid && ready)
        begin
            board.note(start_serial, end_serial, mode);
        end
        if (rst_n && count_valid && count_ready)
        begin
            board.check(day_count, invalid);
        end
    end

    // run ends if no word moves on either side for too long
    always @(posedge clk)
    begin
        if ((valid && ready) || (count_valid && count_ready))
        begin
            quiet <= 0;
        end
        else
        begin
            quiet <= quiet + 1;
            if (quiet + 1 >= QUIET_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [SERIAL_W-1:0] s1, input logic [SERIAL_W-1:0] s2,
                             input logic [1:0] mode_bits);
        while ($urandom_range(99) < idle_pct)
        begin
            valid <= 1'b0;
            @(posedge clk);
        end
        valid <= 1'b1;
        start_serial <= s1;
        end_serial <= s2;
        mode <= mode_bits;
        do
        begin
            @(posedge clk);
        end
        while (!ready);
    endtask

    // mostly valid dates, many near month ends, a few out of range
    function automatic logic [SERIAL_W-1:0] random_serial();
        int pick;
        int s;
        pick = $urandom_range(99);
        if (pick < 2)
        begin
            return '0;
        end
        else if (pick < 5)
        begin
            return SERIAL_W'($urandom_range(131071, SERIAL_MAX + 1));
        end
        else if (pick < 45)
        begin
            s = day_count_board::month_first_serial($urandom_range(12, 1), $urandom_range(199));
            case ($urandom_range(3))
                0:       s = s - 1;
                1:       s = s;
                default: s = s + $urandom_range(30, 27);
            endcase
            if (s > int'(SERIAL_MAX))
            begin
                s = SERIAL_MAX;
            end
            return SERIAL_W'(s);
        end
        return SERIAL_W'($urandom_range(SERIAL_MAX, 1));
    endfunction

    task automatic send_random_words(input int n);
        logic [SERIAL_W-1:0] s1;
        logic [SERIAL_W-1:0] s2;
        repeat (n)
        begin
            s1 = random_serial();
            s2 = random_serial();
            send_word(s1, s2, 2'($urandom_range(3)));
        end
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        valid = 1'b0;
        start_serial = '0;
        end_serial = '0;
        mode = MODE_US;
        count_ready = 1'b0;
        quiet = 0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 14;
        stall_pct = 73;
        // range ends and out-of-range serials
        send_word(SERIAL_W'(1), SERIAL_W'(SERIAL_MAX), MODE_US);
        send_word(SERIAL_W'(SERIAL_MAX), SERIAL_W'(1), MODE_ACT);
        send_word(SERIAL_W'(0), SERIAL_W'(100), MODE_US);
        send_word(SERIAL_W'(100), SERIAL_W'(SERIAL_MAX + 1), MODE_EU);
        send_word(SERIAL_W'(131071), SERIAL_W'(131071), MODE_ACT);
        send_word(SERIAL_W'(0), SERIAL_W'(0), MODE_EU);
        send_word(SERIAL_W'(SERIAL_MAX + 1), SERIAL_W'(1), MODE_ALT);
        send_word(SERIAL_W'(131071), SERIAL_W'(1), MODE_US);
        send_word(SERIAL_W'(1), SERIAL_W'(1), MODE_ALT);
        send_word(SERIAL_W'(SERIAL_MAX), SERIAL_W'(SERIAL_MAX), MODE_US);
        // 29 feb 1900 to 1 mar 1900
        send_word(SERIAL_W'(60), SERIAL_W'(61), MODE_US);
        send_word(SERIAL_W'(60), SERIAL_W'(60), MODE_EU);
        // jan 31 / jan 30 / jan 29 against mar 31
        send_word(SERIAL_W'(31), SERIAL_W'(91), MODE_US);
        send_word(SERIAL_W'(31), SERIAL_W'(91), MODE_EU);
        send_word(SERIAL_W'(30), SERIAL_W'(91), MODE_US);
        send_word(SERIAL_W'(29), SERIAL_W'(91), MODE_US);
        send_word(SERIAL_W'(29), SERIAL_W'(91), MODE_EU);
        // end before start, and a pair each way around serial 65536
        send_word(SERIAL_W'(91), SERIAL_W'(31), MODE_ACT);
        send_word(SERIAL_W'(91), SERIAL_W'(31), MODE_ALT);
        send_word(SERIAL_W'(91), SERIAL_W'(29), MODE_US);
        send_word(SERIAL_W'(65535), SERIAL_W'(65536), MODE_US);
        send_word(SERIAL_W'(65536), SERIAL_W'(65535), MODE_EU);

        send_random_words(RANDOM_PER_PHASE);
        idle_pct = 73;
        stall_pct = 14;
        send_random_words(RANDOM_PER_PHASE);
        idle_pct = 0;
        stall_pct = 0;
        send_random_words(RANDOM_PER_PHASE);
        valid <= 1'b0;

        while (board.owed.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d words (30/360 us %0d, 30e/360 %0d, actual %0d, spare code %0d)",
                 board.words_in, board.per_basis[0], board.per_basis[1],
                 board.per_basis[2], board.per_basis[3]);
        $display("checked %0d result words, %0d out-of-range pairs, %0d errors",
                 board.words_out, board.flagged, board.errors);
        if (board.errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
